// ===== rtl/http_byte_range_parser_unit_defines.svh =====
// Assertion macros of the byte-range parser RTL.
// Included by the module that carries concurrent checks; depends on nothing.
`ifndef HTTP_BYTE_RANGE_PARSER_UNIT_DEFINES_SVH
`define HTTP_BYTE_RANGE_PARSER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// Check sampled on the rising clock edge, switched off while reset is held.
`define BRP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Check sampled on the rising clock edge, also during reset.
`define BRP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define BRP_ASSERT(lbl, prop, msg)
`define BRP_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ===== rtl/brp_pkg.sv =====
// Package of the byte-range parser: widths, phase and radix codes, state type
// and the per-character update functions. Depends on nothing.
package brp_pkg;

  localparam int unsigned CHAR_W  = 8;
  localparam int unsigned START_W = 64;
  localparam int unsigned END_W   = 63;
  localparam int unsigned WIDE_W  = END_W + 4;

  // Parser phases
  localparam logic [3:0] PH_PREFIX  = 4'd0;
  localparam logic [3:0] PH_LEAD    = 4'd1;
  localparam logic [3:0] PH_A_ZERO  = 4'd2;
  localparam logic [3:0] PH_A_X     = 4'd3;
  localparam logic [3:0] PH_A_NUM   = 4'd4;
  localparam logic [3:0] PH_A_AFTER = 4'd5;
  localparam logic [3:0] PH_B_WS    = 4'd6;
  localparam logic [3:0] PH_B_ZERO  = 4'd7;
  localparam logic [3:0] PH_B_X     = 4'd8;
  localparam logic [3:0] PH_B_NUM   = 4'd9;
  localparam logic [3:0] PH_S_WS    = 4'd10;
  localparam logic [3:0] PH_S_ZERO  = 4'd11;
  localparam logic [3:0] PH_S_X     = 4'd12;
  localparam logic [3:0] PH_S_NUM   = 4'd13;
  localparam logic [3:0] PH_DONE    = 4'd14;
  localparam logic [3:0] PH_TERM    = 4'd15;

  // Number bases
  localparam logic [1:0] RADIX_DEC = 2'd0;
  localparam logic [1:0] RADIX_OCT = 2'd1;
  localparam logic [1:0] RADIX_HEX = 2'd2;

  // Outcome of one character inside a number
  localparam logic [1:0] NUM_MORE  = 2'd0;
  localparam logic [1:0] NUM_END   = 2'd1;
  localparam logic [1:0] NUM_END_X = 2'd2;
  localparam logic [1:0] NUM_OVF   = 2'd3;

  localparam logic [3:0] PREFIX_LEN = 4'd6;
  localparam logic [3:0] MIN_LEN    = 4'd8;
  localparam logic [3:0] COUNT_MAX  = 4'd15;

  localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_DASH  = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_COMMA = 8'h2C;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
  localparam logic [CHAR_W-1:0] CH_LO_A  = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LO_F  = 8'h66;
  localparam logic [CHAR_W-1:0] CH_UP_A  = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UP_F  = 8'h46;
  localparam logic [CHAR_W-1:0] CH_LO_X  = 8'h78;
  localparam logic [CHAR_W-1:0] CH_UP_X  = 8'h58;

  typedef struct packed {
    logic [3:0]         phase;
    logic [3:0]         count;
    logic [END_W-1:0]   acc;
    logic [START_W-1:0] first;
    logic [1:0]         radix;
    logic               err;
  } state_t;

  typedef struct packed {
    logic [1:0] kind;
    state_t     st;
  } num_res_t;

  localparam state_t STATE_RESET = '{
    phase: PH_PREFIX, count: 4'd0, acc: '0, first: '0, radix: RADIX_DEC, err: 1'b0
  };

  // Expected byte of the literal prefix at a given position.
  function automatic logic [CHAR_W-1:0] prefix_char(logic [2:0] idx);
    logic [CHAR_W-1:0] ch;
    case (idx)
      3'd0:    ch = 8'h62;
      3'd1:    ch = 8'h79;
      3'd2:    ch = 8'h74;
      3'd3:    ch = 8'h65;
      3'd4:    ch = 8'h73;
      3'd5:    ch = 8'h3D;
      default: ch = CH_NUL;
    endcase
    return ch;
  endfunction

  function automatic logic is_ws(logic [CHAR_W-1:0] c);
    return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic logic is_dec(logic [CHAR_W-1:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  // Digit value in any base up to 16; 16 marks a non-digit.
  function automatic logic [4:0] digit_value(logic [CHAR_W-1:0] c);
    logic [CHAR_W-1:0] t;
    logic [4:0]        d;
    t = '0;
    d = 5'd16;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      t = c - CH_ZERO;
      d = t[4:0];
    end else if (c >= CH_LO_A && c <= CH_LO_F) begin
      t = c - CH_LO_A + 8'd10;
      d = t[4:0];
    end else if (c >= CH_UP_A && c <= CH_UP_F) begin
      t = c - CH_UP_A + 8'd10;
      d = t[4:0];
    end
    return d;
  endfunction

  function automatic state_t finish_bad(state_t s);
    state_t r;
    r = s;
    r.err   = 1'b1;
    r.first = '0;
    r.acc   = '0;
    r.phase = PH_DONE;
    return r;
  endfunction

  function automatic state_t finish_open(state_t s);
    state_t r;
    r = s;
    r.acc   = '0;
    r.phase = PH_DONE;
    return r;
  endfunction

  // Second number closes the range; it must not lie below the first.
  function automatic state_t finish_second(state_t s, logic [END_W-1:0] v);
    state_t r;
    r = s;
    if ({1'b0, v} < s.first) begin
      r = finish_bad(s);
    end else begin
      r.acc   = v;
      r.phase = PH_DONE;
    end
    return r;
  endfunction

  // Suffix form: the start is the negated length.
  function automatic state_t finish_suffix(state_t s, logic [END_W-1:0] v);
    state_t r;
    r = s;
    r.first = '0 - {1'b0, v};
    r.acc   = '0;
    r.phase = PH_DONE;
    return r;
  endfunction

  function automatic state_t start_number(state_t s, logic [CHAR_W-1:0] c,
                                          logic [3:0] zp);
    state_t            r;
    logic [CHAR_W-1:0] t;
    r = s;
    t = c - CH_ZERO;
    if (c == CH_ZERO) begin
      r.acc   = '0;
      r.phase = zp;
    end else begin
      r.radix = RADIX_DEC;
      r.acc   = {{(END_W-CHAR_W){1'b0}}, t};
      r.phase = zp + 4'd2;
    end
    return r;
  endfunction

  // One character inside a number whose zero phase is zp.
  function automatic num_res_t num_step(state_t s, logic [CHAR_W-1:0] c,
                                        logic [3:0] zp);
    num_res_t          r;
    logic [4:0]        d;
    logic [4:0]        rv;
    logic [WIDE_W-1:0] ext;
    logic [WIDE_W-1:0] prod;
    logic [WIDE_W-1:0] wide;
    r.kind = NUM_MORE;
    r.st   = s;
    d      = digit_value(c);
    ext    = {4'b0, s.acc};
    case (s.radix)
      RADIX_OCT: begin
        rv   = 5'd8;
        prod = ext << 3;
      end
      RADIX_HEX: begin
        rv   = 5'd16;
        prod = ext << 4;
      end
      default: begin
        rv   = 5'd10;
        prod = (ext << 3) + (ext << 1);
      end
    endcase
    wide = prod + {{(WIDE_W-5){1'b0}}, d};
    if (s.phase == zp) begin
      if (c == CH_LO_X || c == CH_UP_X) begin
        r.st.phase = zp + 4'd1;
      end else if (d < 5'd8) begin
        r.st.radix = RADIX_OCT;
        r.st.acc   = {{(END_W-5){1'b0}}, d};
        r.st.phase = zp + 4'd2;
      end else begin
        r.st.acc = '0;
        r.kind   = NUM_END;
      end
    end else if (s.phase == zp + 4'd1) begin
      if (d < 5'd16) begin
        r.st.radix = RADIX_HEX;
        r.st.acc   = {{(END_W-5){1'b0}}, d};
        r.st.phase = zp + 4'd2;
      end else begin
        r.st.acc = '0;
        r.kind   = NUM_END_X;
      end
    end else if (d < rv) begin
      if (wide[WIDE_W-1:END_W] != 4'd0) begin
        r.kind = NUM_OVF;
      end else begin
        r.st.acc = wide[END_W-1:0];
      end
    end else begin
      r.kind = NUM_END;
    end
    return r;
  endfunction

  function automatic state_t after_first(state_t s, logic [CHAR_W-1:0] c);
    state_t r;
    r = s;
    if (!is_ws(c)) begin
      if (c == CH_DASH) r.phase = PH_B_WS;
      else r = finish_bad(s);
    end
    return r;
  endfunction

  // Parser update for one non-NUL character.
  function automatic state_t process_char(state_t s, logic [CHAR_W-1:0] c);
    state_t   r;
    num_res_t n;
    r = s;
    n = '0;
    case (s.phase)
      PH_PREFIX: begin
        if (s.count >= PREFIX_LEN || c != prefix_char(s.count[2:0])) r = finish_bad(s);
        else if (s.count == PREFIX_LEN - 4'd1) r.phase = PH_LEAD;
      end
      PH_LEAD: begin
        if (!is_ws(c)) begin
          if (is_dec(c)) r = start_number(s, c, PH_A_ZERO);
          else if (c == CH_DASH) r.phase = PH_S_WS;
          else r = finish_bad(s);
        end
      end
      PH_A_ZERO, PH_A_X, PH_A_NUM: begin
        n = num_step(s, c, PH_A_ZERO);
        r = n.st;
        if (n.kind == NUM_END) begin
          r.first = {1'b0, r.acc};
          r.phase = PH_A_AFTER;
          r = after_first(r, c);
        end else if (n.kind != NUM_MORE) begin
          r = finish_bad(r);
        end
      end
      PH_A_AFTER: r = after_first(s, c);
      PH_B_WS: begin
        if (!is_ws(c)) begin
          if (c == CH_COMMA) r = finish_open(s);
          else if (is_dec(c)) r = start_number(s, c, PH_B_ZERO);
          else r = finish_second(s, '0);
        end
      end
      PH_B_ZERO, PH_B_X, PH_B_NUM: begin
        n = num_step(s, c, PH_B_ZERO);
        r = n.st;
        if (n.kind == NUM_END || n.kind == NUM_END_X) r = finish_second(r, r.acc);
        else if (n.kind == NUM_OVF) r = finish_bad(r);
      end
      PH_S_WS: begin
        if (!is_ws(c)) begin
          if (is_dec(c)) r = start_number(s, c, PH_S_ZERO);
          else r = finish_suffix(s, '0);
        end
      end
      PH_S_ZERO, PH_S_X, PH_S_NUM: begin
        n = num_step(s, c, PH_S_ZERO);
        r = n.st;
        if (n.kind == NUM_END || n.kind == NUM_END_X) r = finish_suffix(r, r.acc);
        else if (n.kind == NUM_OVF) r = finish_bad(r);
      end
      default: r = s;
    endcase
    return r;
  endfunction

  // Close whatever form is open when the text ends.
  function automatic state_t finalize(state_t s);
    state_t r;
    r = s;
    case (s.phase)
      PH_B_WS:                     r = finish_open(s);
      PH_B_ZERO, PH_B_X, PH_B_NUM: r = finish_second(s, s.acc);
      PH_S_WS:                     r = finish_suffix(s, '0);
      PH_S_ZERO, PH_S_X, PH_S_NUM: r = finish_suffix(s, s.acc);
      PH_DONE, PH_TERM:            r = s;
      default:                     r = finish_bad(s);
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/brp_in_if.sv =====
// Input channel of the byte-range parser: one header character per transaction.
// Depends on brp_pkg for the character width.
interface brp_in_if;
  import brp_pkg::*;

  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_in;
  logic              is_last;

  modport source (output valid, output char_in, output is_last, input ready);
  modport sink (input valid, input char_in, input is_last, output ready);
endinterface

// ===== rtl/brp_out_if.sv =====
// Result channel of the byte-range parser: one parsed range per transaction.
// Depends on brp_pkg for the field widths.
interface brp_out_if;
  import brp_pkg::*;

  logic                      valid;
  logic                      ready;
  logic                      status;
  logic signed [START_W-1:0] first_byte;
  logic [END_W-1:0]          last_byte;

  modport source (output valid, output status, output first_byte, output last_byte,
                  input ready);
  modport sink (input valid, input status, input first_byte, input last_byte,
                output ready);
endinterface

// ===== rtl/http_byte_range_parser_unit.sv =====
// Byte-range parser for the value of an HTTP Range header.
// The text enters one character per input transaction; the character marked
// last yields one result transaction with the status and the parsed range.
// Both channels use a valid/ready handshake (brp_in_if, brp_out_if).
// Each character updates the parser state in the cycle it is accepted, so a
// character may be accepted in every cycle; the work per character is one
// constant-base multiply-add and compare on the 63-bit accumulator.
// The result appears on the output register in the cycle after its last
// character is accepted. While a result waits and the receiver holds ready
// low, the input stalls; when the result is taken in the same cycle, a new
// character is still accepted.
// Status 1 marks an invalid range, and then both offsets read zero. A
// negative start means the last that many bytes; an end of zero means open.
// After a result the parser returns to its reset state, ready for the next
// header. Reset is asynchronous, active low, and clears the parser state and
// the result valid flag; no clearing pass is needed.
// Depends on brp_pkg, brp_in_if, brp_out_if and the assertion macro header.
`include "http_byte_range_parser_unit_defines.svh"

module http_byte_range_parser_unit (
  input logic      clk_i,
  input logic      rst_ni,
  brp_in_if.sink   in_i,
  brp_out_if.source out_o
);
  import brp_pkg::*;

  state_t                st_q, st_d;
  logic                  out_valid_q, out_valid_d;
  logic                  status_q, status_d;
  logic [START_W-1:0]    start_q, start_d;
  logic [END_W-1:0]      end_q, end_d;
  logic                  in_fire;
  logic                  last_fire;
  state_t                st_step;
  state_t                st_fin;
  logic                  bad;

  // The input stalls only while a result waits and is not taken.
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign in_fire    = in_i.valid && in_i.ready;
  assign last_fire  = in_fire && in_i.is_last;

  // Parser update for the accepted character, then the close at the last one.
  always_comb begin
    st_step = st_q;
    if (st_q.phase != PH_TERM) begin
      if (in_i.char_in == CH_NUL) begin
        st_step       = finalize(st_q);
        st_step.phase = PH_TERM;
      end else begin
        st_step = process_char(st_q, in_i.char_in);
        if (st_q.count < COUNT_MAX) st_step.count = st_q.count + 4'd1;
      end
    end
    st_fin = finalize(st_step);
    bad    = st_fin.err || (st_fin.count < MIN_LEN);

    st_d = st_q;
    if (last_fire) st_d = STATE_RESET;
    else if (in_fire) st_d = st_step;

    status_d = status_q;
    start_d  = start_q;
    end_d    = end_q;
    if (last_fire) begin
      status_d = bad;
      start_d  = bad ? '0 : st_fin.first;
      end_d    = bad ? '0 : st_fin.acc;
    end

    out_valid_d = out_valid_q;
    if (last_fire) out_valid_d = 1'b1;
    else if (out_o.ready) out_valid_d = 1'b0;
  end

  // Control state: parser state and the result valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= STATE_RESET;
      out_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Result payload register.
  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    start_q  <= start_d;
    end_q    <= end_d;
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.status     = status_q;
  assign out_o.first_byte = start_q;
  assign out_o.last_byte  = end_q;

  // An invalid range carries zero offsets.
  `BRP_ASSERT(a_bad_zero, out_valid_q && status_q |-> start_q == '0 && end_q == '0,
              "invalid result with non-zero offsets")
  // A new result only follows a last character.
  `BRP_ASSERT(a_rise_src, $rose(out_valid_q) |-> $past(last_fire),
              "result without a last character")
  // The parser is back at its reset state after every result.
  `BRP_ASSERT(a_restart, last_fire |=> st_q == STATE_RESET,
              "parser not restarted after a result")
  // A closed range has its end at or above a non-negative start.
  `BRP_ASSERT(a_order, out_valid_q && !status_q && end_q != '0 |->
              !start_q[START_W-1] && (start_q <= {1'b0, end_q}),
              "closed range out of order")
  // The counter stays below the prefix length while the prefix is matched.
  `BRP_ASSERT_ALWAYS(a_prefix_cnt, st_q.phase == PH_PREFIX |-> st_q.count < PREFIX_LEN,
                     "prefix phase beyond the prefix length")

endmodule
